### rtl/core/ihex_pkg.sv
package ihex_pkg;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [23:0] image_offset;
		logic [23:0] word_data;
		logic [13:0] page_number;
		logic [23:0] words_total;
		logic        last;
	} out_item_t;

	localparam logic [3:0] ST_WORD     = 4'd0;
	localparam logic [3:0] ST_REC_OK   = 4'd1;
	localparam logic [3:0] ST_EOF      = 4'd2;
	localparam logic [3:0] ST_NO_COLON = 4'd3;
	localparam logic [3:0] ST_COUNT    = 4'd4;
	localparam logic [3:0] ST_CHECKSUM = 4'd5;
	localparam logic [3:0] ST_LENGTH   = 4'd6;
	localparam logic [3:0] ST_ALIGN    = 4'd7;
	localparam logic [3:0] ST_ADDRESS  = 4'd8;
	localparam logic [3:0] ST_TYPE     = 4'd9;
	localparam logic [3:0] ST_ENDED    = 4'd10;

	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF  = 8'h01;
	localparam logic [7:0] REC_ELA  = 8'h04;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [23:0] FLASH_LIMIT_RESET = 24'd175104;

	function automatic logic [7:0] digit_value(input logic [7:0] c);
		if (c >= 8'h61)      digit_value = c - 8'h61 + 8'd10;
		else if (c >= 8'h41) digit_value = c - 8'h41 + 8'd10;
		else                 digit_value = c - 8'h30;
	endfunction

endpackage

### rtl/core/ihex_page_div.sv
// Offset to page: multiply by the rounded-up reciprocal of the page size; the quotient is registered on start.
module ihex_page_div #(
	parameter int PAGE_BYTES = 1536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] dividend,
	output logic        done,
	output logic [13:0] quotient
);
	localparam int          SHIFT      = 24 + $clog2(PAGE_BYTES);
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1) /
		64'(PAGE_BYTES);
	localparam logic [24:0] RECIP      = RECIP_WIDE[24:0];

	logic [48:0] prod;
	logic [48:0] quo_wide;
	logic [13:0] quo_q;

	assign prod     = 49'(dividend) * 49'(RECIP);
	assign quo_wide = prod >> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
		end else if (start) begin
			quo_q <= quo_wide[13:0];
		end
	end

	assign done     = !start;
	assign quotient = quo_q;
endmodule

### rtl/core/intel_hex_word_loader.sv
// Intel HEX word loader.
// Input channel (in_valid/in_ready/in_data): one text character a transfer,
// or an end-of-input marker. Output channel (out_valid/out_ready/out_data):
// result items; the final result of one input carries last.
// Configuration: cfg_we with cfg_wdata writes flash_limit; the user must
// write it only while idle, the block does not enforce this. A plain
// character is accepted, then makes the record memory write or phase update.
// A newline is decoded, the record header is read from the record memory and
// the checks run; an error or end-of-file result is loaded then. An extended
// address record then reads its address bytes and loads its result. Each data
// word is read from the record memory (the page comes from a registered
// reciprocal multiply) and loaded into the output register once it is free;
// later reads can run while a result waits; the closing result comes last.
// Each result waits in the output register until it is transferred; hold the
// next word back while one is waiting, and keep in_ready low while any result
// is held, so a stalled receiver stalls the input.
// Reset clears control state; the record memory holds no reset value and
// every byte whose value is used was written earlier on the same line. After
// an error, an end-of-file record or the end of input the block drops all
// further characters without results until reset.
module intel_hex_word_loader #(
	parameter int MAX_LINE_DIGITS = 510,
	parameter int PAGE_BYTES      = 1536
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ihex_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ihex_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [23:0]         cfg_wdata
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHAR  = 9'b000000010,
		S_HDR   = 9'b000000100,
		S_CHECK = 9'b000001000,
		S_ELA   = 9'b000010000,
		S_WRD   = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_OUT   = 9'b010000000,
		S_DEAD  = 9'b100000000
	} state_t;

	state_t state_q;
	logic [7:0] mem [256];
	logic [7:0] rd_q;
	logic [7:0] raddr;
	logic       rd_en;

	logic        phase_q, fin_q, at_end_q;
	logic [9:0]  dcnt_q;
	logic [7:0]  hi_q, sum_q, len_q, a1_q, a2_q, type_q, b0_q, b1_q;
	logic [15:0] upper_q;
	logic [23:0] wc_q, limit_q, off_q;
	logic [23:0] wd_q;
	logic [2:0]  step_q;
	logic [7:0]  base_q;
	logic [5:0]  words_left_q;
	ihex_pkg::in_item_t ch_q;

	logic        div_start, div_done;
	logic [13:0] div_q;

	ihex_page_div #(.PAGE_BYTES(PAGE_BYTES)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(off_q),
		.done(div_done), .quotient(div_q)
	);

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	// Record memory: one write, one registered read a cycle.
	logic       wr_en;
	logic [7:0] wr_addr, wr_byte, dv;
	assign dv      = ihex_pkg::digit_value(ch_q.char_code);
	assign wr_byte = hi_q | dv;
	assign wr_addr = dcnt_q[8:1];
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_byte;
		if (rd_en) rd_q <= mem[raddr];
	end

	// word address of the record: full byte address halved, all 31 bits kept
	logic [30:0] fword;
	assign fword = {upper_q, a1_q, a2_q[7:1]};

	always_comb begin
		wr_en = 1'b0;
		rd_en = 1'b0;
		raddr = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_CHAR: begin
				wr_en = phase_q && !ch_q.end_of_input && ch_q.char_code != ihex_pkg::CH_NL &&
					ch_q.char_code > ihex_pkg::CH_SPACE &&
					dcnt_q < 10'(MAX_LINE_DIGITS) && dcnt_q[0];
			end
			S_HDR: begin
				rd_en = 1'b1;
				raddr = 8'(step_q);
			end
			S_ELA: begin
				rd_en = 1'b1;
				raddr = 8'(step_q) + 8'd4;
			end
			S_WRD: begin
				rd_en = 1'b1;
				raddr = base_q + 8'(step_q);
				div_start = (step_q == 3'd0);
			end
			default: ;
		endcase
	end

	task automatic put(input logic [3:0] st, input logic lst);
		out_valid <= 1'b1;
		out_data  <= '{status: st, image_offset: '0, word_data: '0, page_number: '0,
			words_total: wc_q, last: lst};
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid    <= 1'b0;
			out_data     <= '0;
			phase_q      <= 1'b0;
			fin_q        <= 1'b0;
			dcnt_q       <= '0;
			hi_q         <= '0;
			sum_q        <= '0;
			upper_q      <= '0;
			wc_q         <= '0;
			limit_q      <= ihex_pkg::FLASH_LIMIT_RESET;
			at_end_q     <= 1'b0;
			step_q       <= '0;
			ch_q         <= '0;
			len_q        <= '0;
			a1_q         <= '0;
			a2_q         <= '0;
			type_q       <= '0;
			b0_q         <= '0;
			b1_q         <= '0;
			wd_q         <= '0;
			off_q        <= '0;
			base_q       <= '0;
			words_left_q <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						ch_q    <= in_data;
						state_q <= fin_q ? S_IDLE : S_CHAR;
					end
				end
				S_CHAR: begin
					state_q <= S_IDLE;
					if (ch_q.end_of_input) begin
						if (!phase_q) begin
							fin_q <= 1'b1;
							put(ihex_pkg::ST_ENDED, 1'b1);
						end else begin
							at_end_q <= 1'b1;
							state_q  <= S_HDR;
							step_q   <= '0;
						end
					end else if (!phase_q) begin
						if (ch_q.char_code == ihex_pkg::CH_COLON) begin
							phase_q <= 1'b1;
							dcnt_q  <= '0;
							sum_q   <= '0;
							hi_q    <= '0;
						end else begin
							fin_q <= 1'b1;
							put(ihex_pkg::ST_NO_COLON, 1'b1);
						end
					end else if (ch_q.char_code == ihex_pkg::CH_NL) begin
						at_end_q <= 1'b0;
						state_q  <= S_HDR;
						step_q   <= '0;
					end else if (ch_q.char_code <= ihex_pkg::CH_SPACE) begin
						state_q <= S_IDLE;
					end else if (dcnt_q >= 10'(MAX_LINE_DIGITS)) begin
						fin_q <= 1'b1;
						put(ihex_pkg::ST_LENGTH, 1'b1);
					end else begin
						if (!dcnt_q[0]) hi_q <= {dv[3:0], 4'd0};
						else sum_q <= sum_q + wr_byte;
						dcnt_q <= dcnt_q + 10'd1;
					end
				end
				S_HDR: begin
					// reads issue at step 0..3, each byte is taken from rd_q at the next step
					step_q <= step_q + 3'd1;
					unique case (step_q)
						3'd1: len_q <= rd_q;
						3'd2: a1_q  <= rd_q;
						3'd3: a2_q  <= rd_q;
						3'd4: begin
							type_q  <= rd_q;
							state_q <= S_CHECK;
						end
						default: ;
					endcase
				end
				S_CHECK: begin
					// close the line, then run the record checks in order
					phase_q <= 1'b0;
					dcnt_q  <= '0;
					sum_q   <= '0;
					hi_q    <= '0;
					state_q <= S_IDLE;
					if (dcnt_q[0] || dcnt_q < 10'd10) begin
						fin_q <= 1'b1; put(ihex_pkg::ST_LENGTH, 1'b1);
					end else if (sum_q != 8'd0) begin
						fin_q <= 1'b1; put(ihex_pkg::ST_CHECKSUM, 1'b1);
					end else if (dcnt_q[9:1] != 9'd5 + 9'(len_q)) begin
						fin_q <= 1'b1; put(ihex_pkg::ST_COUNT, 1'b1);
					end else if (type_q == ihex_pkg::REC_DATA) begin
						if (len_q[1:0] != 2'd0) begin
							fin_q <= 1'b1; put(ihex_pkg::ST_ALIGN, 1'b1);
						end else if (fword >= {7'd0, limit_q}) begin
							fin_q <= 1'b1; put(ihex_pkg::ST_ADDRESS, 1'b1);
						end else begin
							off_q        <= 24'(fword[23:1] * 24'd3);
							words_left_q <= len_q[7:2];
							base_q       <= 8'd4;
							step_q       <= '0;
							state_q      <= (len_q[7:2] == 6'd0) ? S_OUT : S_WRD;
						end
					end else if (type_q == ihex_pkg::REC_ELA && len_q == 8'd2) begin
						step_q  <= '0;
						state_q <= S_ELA;
					end else if (type_q == ihex_pkg::REC_EOF) begin
						fin_q <= 1'b1; put(ihex_pkg::ST_EOF, 1'b1);
					end else begin
						fin_q <= 1'b1; put(ihex_pkg::ST_TYPE, 1'b1);
					end
				end
				S_ELA: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd1) upper_q[15:8] <= rd_q;
					if (step_q == 3'd2) begin
						upper_q[7:0] <= rd_q;
						state_q      <= S_OUT;
					end
				end
				S_WRD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd1) b0_q <= rd_q;
					if (step_q == 3'd2) b1_q <= rd_q;
					if (step_q == 3'd3) begin
						wd_q    <= {rd_q, b0_q, b1_q};
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done && !out_valid) begin
						out_valid <= 1'b1;
						out_data  <= '{status: ihex_pkg::ST_WORD, image_offset: off_q,
							word_data: wd_q, page_number: div_q,
							words_total: wc_q + 24'd1, last: 1'b0};
						wc_q         <= wc_q + 24'd1;
						off_q        <= off_q + 24'd3;
						base_q       <= base_q + 8'd4;
						words_left_q <= words_left_q - 6'd1;
						step_q       <= '0;
						state_q      <= (words_left_q == 6'd1) ? S_OUT : S_WRD;
					end
				end
				S_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						out_data  <= '{status: at_end_q ? ihex_pkg::ST_ENDED : ihex_pkg::ST_REC_OK,
							image_offset: '0, word_data: '0, page_number: '0,
							words_total: wc_q, last: 1'b1};
						if (at_end_q) fin_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped");
	a_dead: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q && state_q == S_IDLE |=> state_q == S_IDLE) else $error("ran after stop");
`endif
endmodule

### tb/tb_intel_hex_word_loader.sv
`timescale 1ns / 1ps

module tb_intel_hex_word_loader;
	import ihex_pkg::*;

	localparam int MAX_DIGITS  = 510;
	localparam int PAGE_SIZE   = 1536;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN       = 60;

	// Mirror of the loader: decodes the same text and predicts every result
	class hex_word_tracker;
		logic [7:0]  rec_mem [256];
		bit          in_line;
		int unsigned ndig;
		logic [7:0]  hi_nib;
		logic [7:0]  sum;
		logic [15:0] upper;
		logic [23:0] words;
		bit          stopped;
		logic [23:0] limit;
		out_item_t   due [$];
		int          errors;
		int          matched;
		logic [3:0]  stop_code;

		function new();
			in_line   = 0;
			ndig      = 0;
			hi_nib    = 0;
			sum       = 0;
			upper     = 0;
			words     = 0;
			stopped   = 0;
			limit     = FLASH_LIMIT_RESET;
			errors    = 0;
			matched   = 0;
			stop_code = ST_WORD;
		endfunction

		function logic [7:0] nibble_of(logic [7:0] c);
			logic [7:0] v;
			if (c >= 8'h61)
				v = c - 8'h57;
			else if (c >= 8'h41)
				v = c - 8'h37;
			else
				v = c - 8'h30;
			return v;
		endfunction

		function void push(logic [3:0] st, logic [23:0] off, logic [23:0] w, logic [13:0] pg);
			out_item_t r;
			r.status       = st;
			r.image_offset = off;
			r.word_data    = w;
			r.page_number  = pg;
			r.words_total  = words;
			r.last         = 1'b0;
			due.push_back(r);
		endfunction

		function void halt(logic [3:0] st);
			stopped   = 1;
			stop_code = st;
			push(st, '0, '0, '0);
		endfunction

		function void close_line(bit at_end);
			int unsigned cnt;
			logic [7:0]  s, len, typ;
			logic [15:0] addr;
			logic [31:0] f, o;
			logic [7:0]  b;
			logic [23:0] off;
			cnt     = ndig;
			s       = sum;
			in_line = 0;
			ndig    = 0;
			sum     = 0;
			hi_nib  = 0;
			if (cnt[0] || cnt < 10) begin
				halt(ST_LENGTH);
				return;
			end
			if (s != 0) begin
				halt(ST_CHECKSUM);
				return;
			end
			len  = rec_mem[0];
			addr = {rec_mem[1], rec_mem[2]};
			typ  = rec_mem[3];
			if (cnt / 2 != 5 + len) begin
				halt(ST_COUNT);
				return;
			end
			if (typ == REC_DATA) begin
				f = {upper, addr} >> 1;
				if (len[1:0] != 0) begin
					halt(ST_ALIGN);
					return;
				end
				if (f >= {8'd0, limit}) begin
					halt(ST_ADDRESS);
					return;
				end
				o = (f >> 1) * 3;
				for (int i = 0; i < len / 4; i++) begin
					b     = 8'(4 + 4 * i);
					off   = o[23:0];
					words = words + 24'd1;
					push(ST_WORD, off, {rec_mem[8'(b + 2)], rec_mem[b], rec_mem[8'(b + 1)]},
						14'(off / PAGE_SIZE));
					o = o + 3;
				end
			end else if (typ == REC_ELA && len == 8'd2) begin
				upper = {rec_mem[4], rec_mem[5]};
			end else if (typ == REC_EOF) begin
				halt(ST_EOF);
				return;
			end else begin
				halt(ST_TYPE);
				return;
			end
			push(at_end ? ST_ENDED : ST_REC_OK, '0, '0, '0);
			if (at_end) begin
				stopped   = 1;
				stop_code = ST_ENDED;
			end
		endfunction

		function void note_input(in_item_t it);
			int         n_due;
			logic [7:0] v, c;
			n_due = due.size();
			c     = it.char_code;
			if (stopped)
				return;
			if (it.end_of_input) begin
				if (!in_line)
					halt(ST_ENDED);
				else
					close_line(1);
			end else if (!in_line) begin
				if (c == CH_COLON) begin
					in_line = 1;
					ndig    = 0;
					sum     = 0;
					hi_nib  = 0;
				end else begin
					halt(ST_NO_COLON);
				end
			end else if (c == CH_NL) begin
				close_line(0);
			end else if (c <= CH_SPACE) begin
				// whitespace inside a line is dropped
			end else if (ndig >= MAX_DIGITS) begin
				halt(ST_LENGTH);
			end else begin
				v = nibble_of(c);
				if (!ndig[0]) begin
					hi_nib = {v[3:0], 4'h0};
				end else begin
					rec_mem[8'(ndig >> 1)] = hi_nib | v;
					sum = sum + (hi_nib | v);
				end
				ndig++;
			end
			if (due.size() > n_due)
				due[due.size() - 1].last = 1'b1;
		endfunction

		task report(string what, logic [23:0] got, logic [23:0] want);
			$display("mismatch %0s: got 0x%0h, want 0x%0h", what, got, want);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t w;
			if (due.size() == 0) begin
				report("unexpected result status", 24'(got.status), '0);
				return;
			end
			w = due.pop_front();
			matched++;
			if (got.status != w.status)
				report("status", 24'(got.status), 24'(w.status));
			if (got.image_offset != w.image_offset)
				report("image_offset", got.image_offset, w.image_offset);
			if (got.word_data != w.word_data)
				report("word_data", got.word_data, w.word_data);
			if (got.page_number != w.page_number)
				report("page_number", 24'(got.page_number), 24'(w.page_number));
			if (got.words_total != w.words_total)
				report("words_total", got.words_total, w.words_total);
			if (got.last != w.last)
				report("last", 24'(got.last), 24'(w.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_we;
	logic [23:0] cfg_wdata;

	hex_word_tracker tracker = new();

	logic [7:0]  line_bytes [$];
	logic [15:0] gen_upper;
	bit          calm;
	bit          quiet;
	bit          squeeze;
	int          nchars;
	int          nrecords;
	int          cycles;

	intel_hex_word_loader #(
		.MAX_LINE_DIGITS(MAX_DIGITS),
		.PAGE_BYTES     (PAGE_SIZE)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Watchdog: abandon the run if the loader locks up
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Receiver: random ready bursts, one long hold-off on request, none when calm
	initial begin : receiver
		int hold;
		int hold_off;
		bit squeezed;
		hold      = 0;
		hold_off  = 0;
		squeezed  = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_result(out_data);
			if (squeeze && !squeezed) begin
				squeezed = 1;
				hold_off = 400;
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else if (hold > 0) begin
				hold--;
			end else if ($urandom_range(0, 4) == 0) begin
				hold = $urandom_range(1, 18) - 1;
				out_ready <= 1'b0;
			end else begin
				hold = $urandom_range(1, 30) - 1;
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one item; valid stays up across back-to-back transfers
	task put(input logic [7:0] c, input bit eoi);
		in_item_t it;
		it.char_code    = c;
		it.end_of_input = eoi;
		if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.note_input(it);
		nchars++;
	endtask

	// Encode a nibble; a high digit may use a loose code above 0x7F
	function logic [7:0] hex_char(logic [3:0] v, bit high_pos);
		if (high_pos && $urandom_range(0, 3) == 0)
			return 8'(8'h57 + v + 16 * $urandom_range(3, 9));
		if (v < 10)
			return 8'h30 + v;
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
	endfunction

	function logic [7:0] blank();
		logic [7:0] w;
		w = 8'($urandom_range(0, 32));
		return (w == CH_NL) ? CH_SPACE : w;
	endfunction

	// Build a record in line_bytes: header, data (0 random, 1 ones, 2 zeros), checksum
	function void frame(logic [7:0] typ, logic [15:0] addr, int len, int fill);
		logic [7:0] s;
		line_bytes = {8'(len), addr[15:8], addr[7:0], typ};
		for (int i = 0; i < len; i++)
			line_bytes.push_back(fill == 1 ? 8'hFF : fill == 2 ? 8'h00 : 8'($urandom));
		s = 0;
		foreach (line_bytes[i])
			s = s + line_bytes[i];
		line_bytes.push_back(-s);
	endfunction

	task send_line(input bit newline, input int extra);
		put(CH_COLON, 0);
		foreach (line_bytes[i]) begin
			if ($urandom_range(0, 7) == 0)
				put(blank(), 0);
			put(hex_char(line_bytes[i][7:4], 1), 0);
			put(hex_char(line_bytes[i][3:0], 0), 0);
		end
		repeat (extra) put(8'h30, 0);
		if (newline)
			put(CH_NL, 0);
		nrecords++;
	endtask

	task ela(input logic [15:0] up);
		frame(REC_ELA, 16'h0000, 2, 0);
		line_bytes[4] = up[15:8];
		line_bytes[5] = up[7:0];
		line_bytes[6] = -(8'd2 + REC_ELA + up[15:8] + up[7:0]);
		send_line(1, 0);
		gen_upper = up;
	endtask

	// Data record at a full byte address, switching the upper address first if needed
	task data_at(input logic [31:0] ba, input int len, input int fill);
		if (ba[31:16] != gen_upper)
			ela(ba[31:16]);
		frame(REC_DATA, ba[15:0], len, fill);
		send_line(1, 0);
	endtask

	// Flash limit changes only once the loader has gone quiet
	task write_limit(input logic [23:0] v);
		in_valid <= 1'b0;
		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.limit = v;
	endtask

	// One way of ending the stream; every one of them stops the parser
	task terminate(input int kind);
		case (kind)
			0: begin
				frame(REC_EOF, 16'h0000, 0, 0);
				send_line(1, 0);
			end
			1: put(($urandom_range(0, 1) ? CH_NL : 8'($urandom_range(0, 57))), 0);
			2: begin
				frame(REC_DATA, 16'h0000, 4, 0);
				line_bytes[0] = line_bytes[0] + 8'd1;
				line_bytes[8] = line_bytes[8] - 8'd1;
				send_line(1, 0);
			end
			3: begin
				frame(REC_DATA, 16'h0010, 8, 0);
				line_bytes[12] = line_bytes[12] + 8'd1;
				send_line(1, 0);
			end
			4: begin
				frame(REC_DATA, 16'h0000, 0, 0);
				send_line(1, 1);
			end
			5: begin
				frame(REC_DATA, 16'h0000, 3, 0);
				send_line(1, 0);
			end
			6: data_at(32'hFFFF_0000, 4, 0);
			7: begin
				if ($urandom_range(0, 1)) begin
					frame(8'h02 + 8'($urandom_range(0, 1)), 16'h0000, 2, 0);
				end else begin
					frame(REC_ELA, 16'h0000, 4, 0);
				end
				send_line(1, 0);
			end
			8: put(8'($urandom), 1);
			9: begin
				frame(REC_DATA, 16'h0020, 8, 0);
				send_line(0, 0);
				put(8'($urandom), 1);
			end
			default: begin
				frame(REC_DATA, 16'h0000, 252, 2);
				send_line(1, 0);
			end
		endcase
	endtask

	initial begin : stimulus
		logic [31:0] ba;
		int          start;
		int          kind;
		logic [23:0] lim;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		calm      = 0;
		quiet     = 0;
		squeeze   = 0;
		nchars    = 0;
		nrecords  = 0;
		gen_upper = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset limit, empty record, all-ones data, top of the flash window
		ela(16'h0000);
		data_at(32'h0000_0000, 0, 0);
		data_at(32'h0000_0000, 4, 1);
		data_at(32'h0005_57F8, 8, 0);
		data_at(32'h0000_05FC, 8, 2);

		// Limit 0x800000: highest admissible address, offsets up to 0xBFFFFD
		write_limit(24'h80_0000);
		data_at(32'h00FF_FFF8, 8, 1);

		// Zero limit: no data record may pass, extended addresses only
		write_limit(24'h00_0000);
		ela(16'h1234);
		ela(16'hFFFF);

		lim = 24'($urandom_range(24'h00_1000, 24'h80_0000));
		write_limit(lim);

		// Random records, all well formed, opening with one long receiver hold-off
		start   = nchars;
		squeeze = 1;
		while (nchars < start + 70) begin
			quiet = ($urandom_range(0, 2) == 0);
			ba = $urandom_range(0, 2 * lim - 1);
			if ($urandom_range(0, 9) == 0)
				ba = 2 * lim - 2 - 4 * $urandom_range(0, 3);
			if ($urandom_range(0, 9) == 0)
				ela(ba[31:16]);
			else
				data_at(ba, 4 * ($urandom_range(0, 9) == 0 ?
					$urandom_range(5, 16) : $urandom_range(0, 4)), 0);
		end

		// Final stretch without idling, then end the stream
		calm  = 1;
		quiet = 0;
		kind  = $urandom_range(0, 10);
		terminate(kind);
		repeat ($urandom_range(2, 6)) put(8'($urandom), $urandom_range(0, 1));
		in_valid <= 1'b0;

		while (tracker.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("covered %0d characters in %0d records, %0d results checked",
			nchars, nrecords, tracker.matched);
		$display("words emitted %0d, stream ended with status %0d",
			tracker.words, tracker.stop_code);
		if (tracker.errors == 0 && tracker.due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
